// ===== hw/rtl/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppressor.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package gbs_pkg;

  localparam int MAX_KEPT_DEF = 256;
  localparam int COORD_W      = 17;
  localparam int THR_W        = 17;
  localparam int POS_W        = 15;

  localparam logic [THR_W-1:0] THR_RESET = 17'd29491;
  localparam logic [POS_W-1:0] POS_MAX   = 15'd32767;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch candidate, clear hit flag, rewind scan index
    logic issue;   // read the next stored box into the compare pipeline
    logic finish;  // decide, store, publish result, update counters
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic store_empty;
    logic scan_last;
    logic pipe_idle;
    logic hit_seen;
  } ctl_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbs_ctrl.sv =====
// Sequencing state machine for the greedy box suppressor.
// Depends on gbs_pkg for the state enum and the command/status structs.
`default_nettype none

module gbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gbs_pkg::ctl_stat_t stat,
  output gbs_pkg::ctl_cmd_t  cmd,
  output logic              busy
);

  gbs_pkg::ctl_state_t state;
  gbs_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gbs_pkg::ST_IDLE: begin
        if (start) begin
          state_next = stat.store_empty ? gbs_pkg::ST_FINISH : gbs_pkg::ST_SCAN;
        end
      end
      gbs_pkg::ST_SCAN: begin
        // stop early once any stored box has suppressed the candidate
        if (stat.hit_seen || stat.scan_last) begin
          state_next = gbs_pkg::ST_DRAIN;
        end
      end
      gbs_pkg::ST_DRAIN: begin
        if (stat.pipe_idle) begin
          state_next = gbs_pkg::ST_FINISH;
        end
      end
      gbs_pkg::ST_FINISH: begin
        state_next = gbs_pkg::ST_IDLE;
      end
      default: begin
        state_next = gbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      gbs_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      gbs_pkg::ST_SCAN: begin
        cmd.issue = !stat.hit_seen;
      end
      gbs_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      gbs_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gbs_datapath.sv =====
// Datapath: candidate registers, kept-box memory, overlap compare pipeline,
// counters and result registers. Depends on gbs_pkg.
`default_nettype none

module gbs_datapath #(
  parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gbs_pkg::ctl_cmd_t                cmd,
  output gbs_pkg::ctl_stat_t               stat,
  input  logic                             cfg_valid,
  input  logic [gbs_pkg::THR_W-1:0]        cfg_data,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_left,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_top,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_right,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_bottom,
  input  logic                             frame_last,
  output logic                             result_valid,
  output logic                             keep,
  output logic [gbs_pkg::POS_W-1:0]        box_index,
  output logic                             store_overflow,
  output logic                             frame_done
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int CWD = gbs_pkg::COORD_W;
  localparam int WORD_W = 4 * CWD;
  localparam int STAGES = 5;

  // Configuration
  logic [gbs_pkg::THR_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= gbs_pkg::THR_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // Candidate
  logic signed [CWD-1:0] c_l, c_t, c_r, c_b;
  logic                  c_last;
  logic signed [CWD:0]   w_a, h_a;
  logic signed [2*CWD+1:0] area_a;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_l    <= box_left;
      c_t    <= box_top;
      c_r    <= box_right;
      c_b    <= box_bottom;
      c_last <= frame_last;
      w_a    <= (CWD+1)'(box_right) - (CWD+1)'(box_left);
      h_a    <= (CWD+1)'(box_bottom) - (CWD+1)'(box_top);
    end
    // settles long before the pipeline stage that reads it
    area_a <= w_a * h_a;
  end

  // Counters
  logic [CW-1:0]             kept_count;
  logic [gbs_pkg::POS_W-1:0] frame_pos;
  logic [AW-1:0]             scan_idx;
  logic                      store_full;
  logic                      hit_any;
  logic                      hit;
  logic [STAGES-1:0]         v;
  logic                      keep_now;

  assign store_full = (kept_count == CW'(MAX_KEPT));
  assign keep_now   = !hit_any;

  assign stat.store_empty = (kept_count == '0);
  assign stat.scan_last   = (CW'(scan_idx) == kept_count - CW'(1));
  assign stat.pipe_idle   = (v == '0);
  assign stat.hit_seen    = hit_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      frame_pos  <= '0;
      scan_idx   <= '0;
      hit_any    <= 1'b0;
      v          <= '0;
    end else begin
      v <= {v[STAGES-2:0], cmd.issue};
      if (cmd.load) begin
        scan_idx <= '0;
        hit_any  <= 1'b0;
      end else begin
        if (cmd.issue) begin
          scan_idx <= scan_idx + AW'(1);
        end
        if (hit) begin
          hit_any <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (c_last) begin
          kept_count <= '0;
          frame_pos  <= '0;
        end else begin
          if (keep_now && !store_full) begin
            kept_count <= kept_count + CW'(1);
          end
          if (frame_pos != gbs_pkg::POS_MAX) begin
            frame_pos <= frame_pos + gbs_pkg::POS_W'(1);
          end
        end
      end
    end
  end

  // Kept-box memory: {bottom, top, right, left}
  logic [WORD_W-1:0] mem [MAX_KEPT];
  logic [WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.finish && keep_now && !store_full) begin
      mem[kept_count[AW-1:0]] <= {c_b, c_t, c_r, c_l};
    end
    if (cmd.issue) begin
      rd_data <= mem[scan_idx];
    end
  end

  // Stage B: widths and clipped overlap extents
  logic signed [CWD-1:0] k_l, k_r, k_t, k_b;
  logic signed [CWD-1:0] min_r, max_l, min_b, max_t;
  logic signed [CWD:0]   ov_w, ov_h;
  logic signed [CWD:0]   w_b, h_b;
  logic [CWD-1:0]        iw, ih;

  assign k_l   = rd_data[CWD-1:0];
  assign k_r   = rd_data[2*CWD-1:CWD];
  assign k_t   = rd_data[3*CWD-1:2*CWD];
  assign k_b   = rd_data[4*CWD-1:3*CWD];
  assign min_r = (c_r < k_r) ? c_r : k_r;
  assign max_l = (c_l > k_l) ? c_l : k_l;
  assign min_b = (c_b < k_b) ? c_b : k_b;
  assign max_t = (c_t > k_t) ? c_t : k_t;
  assign ov_w  = (CWD+1)'(min_r) - (CWD+1)'(max_l);
  assign ov_h  = (CWD+1)'(min_b) - (CWD+1)'(max_t);

  always_ff @(posedge clk) begin
    w_b <= (CWD+1)'(k_r) - (CWD+1)'(k_l);
    h_b <= (CWD+1)'(k_b) - (CWD+1)'(k_t);
    iw  <= ov_w[CWD] ? '0 : ov_w[CWD-1:0];
    ih  <= ov_h[CWD] ? '0 : ov_h[CWD-1:0];
  end

  // Stage C: stored area and intersection
  logic signed [2*CWD+1:0] area_b;
  logic [2*CWD-1:0]        inter_c;

  always_ff @(posedge clk) begin
    area_b  <= w_b * h_b;
    inter_c <= iw * ih;
  end

  // Stage D: union
  logic signed [2*CWD+3:0] uni;
  logic [2*CWD-1:0]        inter_d;

  always_ff @(posedge clk) begin
    uni <= (2*CWD+4)'(area_a) + (2*CWD+4)'(area_b)
         - $signed({4'b0000, inter_c});
    inter_d <= inter_c;
  end

  // Stage E: threshold times union, split in two halves
  localparam int UH = CWD + 1;
  logic                     pos_e;
  logic [UH+gbs_pkg::THR_W-1:0] p_lo, p_hi;
  logic [2*CWD-1:0]         inter_e;
  logic [2*UH-1:0]          u_mag;

  assign u_mag = uni[2*UH-1:0];

  always_ff @(posedge clk) begin
    pos_e   <= !uni[2*CWD+3] && (uni != '0);
    p_lo    <= thr * u_mag[UH-1:0];
    p_hi    <= thr * u_mag[2*UH-1:UH];
    inter_e <= inter_d;
  end

  // Stage F: inter * 65536 > thr * union
  localparam int RW = 2*UH + gbs_pkg::THR_W;
  logic [RW-1:0] rhs, lhs;

  assign rhs = {p_hi, {UH{1'b0}}} + RW'(p_lo);
  assign lhs = RW'({inter_e, 16'h0000});
  assign hit = v[STAGES-1] && pos_e && (lhs > rhs);

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
    if (cmd.finish) begin
      keep           <= keep_now;
      box_index      <= frame_pos;
      store_overflow <= keep_now && store_full;
      frame_done     <= c_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/greedy_box_suppressor.sv =====
// Greedy non-maximum suppression of boxes by intersection over union.
// Top level: joins gbs_ctrl and gbs_datapath; depends on gbs_pkg.
//
// Usage:
//   Present a box (edges in signed Q12.4, frame_last on the frame's final box)
//   and raise start; the item is taken at an edge with start high and busy
//   low. The block compares it against each box kept so far in the frame,
//   one stored box per cycle through a five-stage compare pipeline, and
//   stops reading once one overlap exceeds the threshold.
//   With boxes stored, busy stays high through the scan, the drain of the
//   compare pipeline and the finish state, and the result strobe (result_valid)
//   is registered from the finish state; with an empty store the scan is skipped. The
//   next item may be started in the cycle the strobe is high.
//   Each result stands on keep, box_index, store_overflow and frame_done until
//   the next result; the receiver cannot stall it.
//   iou_threshold is written through cfg_valid/cfg_data; the user must write
//   it only while idle, the block does not enforce it; cfg_ready is always high.
//   Reset sets the threshold to 29491 (about 0.45) and empties the store;
//   stored boxes need no clearing, only the fill count is reset.
`default_nettype none

module greedy_box_suppressor #(
  parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_left,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_top,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_right,
  input  logic signed [gbs_pkg::COORD_W-1:0] box_bottom,
  input  logic                               frame_last,
  output logic                               result_valid,
  output logic                               keep,
  output logic [gbs_pkg::POS_W-1:0]          box_index,
  output logic                               store_overflow,
  output logic                               frame_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gbs_pkg::THR_W-1:0]          cfg_data
);

  gbs_pkg::ctl_cmd_t  cmd;
  gbs_pkg::ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  gbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  gbs_datapath #(
    .MAX_KEPT (MAX_KEPT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_right      (box_right),
    .box_bottom     (box_bottom),
    .frame_last     (frame_last),
    .result_valid   (result_valid),
    .keep           (keep),
    .box_index      (box_index),
    .store_overflow (store_overflow),
    .frame_done     (frame_done)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gbs_checker.sv =====
// Port-level checks for greedy_box_suppressor, attached by bind.
// Depends on gbs_pkg for field widths.
`default_nettype none

module gbs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid,
  input logic                        keep,
  input logic [gbs_pkg::POS_W-1:0]   box_index,
  input logic                        store_overflow,
  input logic                        frame_done
);

  // high until the first result of a frame has been seen
  logic frame_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= 1'b1;
    end else if (result_valid) begin
      frame_start <= frame_done;
    end
  end

  // an overflow is only ever reported on a kept box
  a_overflow_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid && store_overflow |-> keep)
    else $error("store_overflow without keep");

  // an accepted item holds the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // a result ends the work of an item: strobe follows busy and lands idle
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy) && !busy)
    else $error("result strobe outside of item completion");

  // results are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // after a frame end the next result starts the frame at position zero
  a_index_restart: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_start |-> box_index == '0)
    else $error("first result of a frame not at position zero");

endmodule

bind greedy_box_suppressor gbs_checker u_gbs_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .result_valid   (result_valid),
  .keep           (keep),
  .box_index      (box_index),
  .store_overflow (store_overflow),
  .frame_done     (frame_done)
);

`default_nettype wire
